// File: rtl/sha_pkg.sv
`default_nettype none
package sha_pkg;
	typedef struct packed {
		logic load_byte;
		logic load_pad;
		logic load_len;
		logic clear_block;
		logic start_init;
		logic round_en;
		logic finish;
		logic reset_hash;
		logic [5:0] round_idx;
	} sha_cmd_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction
endpackage
`default_nettype wire

// File: rtl/sha_datapath.sv
`default_nettype none
module sha_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sha_pkg::sha_cmd_t cmd,
	input  wire logic [7:0]       msg_byte,
	output logic [5:0]            pos,
	output logic [31:0]           hash_out [8]
);
	import sha_pkg::*;

	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [60:0] count_q;
	logic [63:0] bits;
	logic [31:0] s0, s1, t1, t2, wnext, wt, bs0, bs1, ch, maj;
	logic [31:0] fill_w [16];
	logic [3:0] widx;
	logic [4:0] sh;

	assign pos = count_q[5:0];
	assign widx = count_q[5:2];
	assign sh = {2'd3 - count_q[1:0], 3'd0};
	assign bits = {count_q, 3'd0};
	assign hash_out = h_q;

	assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign wnext = s1 + w_q[9] + s0 + w_q[0];
	assign wt = w_q[0];
	assign bs1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
	assign bs0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
	assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1 = v_q[7] + bs1 + ch + ROUND_K[cmd.round_idx] + wt;
	assign t2 = bs0 + maj;

	always_comb begin
		for (int i = 0; i < 16; i++) fill_w[i] = '0;
		if (cmd.load_len) begin
			fill_w[14] = bits[63:32];
			fill_w[15] = bits[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= INIT_HASH[i];
		end else begin
			if (cmd.load_byte) count_q <= count_q + 61'd1;
			if (cmd.reset_hash) begin
				count_q <= '0;
				for (int i = 0; i < 8; i++) h_q[i] <= INIT_HASH[i];
			end else if (cmd.finish) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			w_q[widx] <= (w_q[widx] & ~(32'hff << sh)) | ({24'd0, msg_byte} << sh);
		end else if (cmd.load_pad) begin
			w_q[widx] <= (w_q[widx] & ~((32'hff << sh) | ((32'hff << sh) - 32'd1)))
				| ({24'd0, PAD_BYTE} << sh);
			for (int i = 0; i < 16; i++) if (i > int'(widx)) w_q[i] <= fill_w[i];
		end else if (cmd.clear_block) begin
			for (int i = 0; i < 16; i++) w_q[i] <= fill_w[i];
		end else if (cmd.round_en) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnext;
		end
		if (cmd.start_init) for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		if (cmd.round_en) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end
endmodule
`default_nettype wire

// File: rtl/sha_ctrl.sv
`default_nettype none
module sha_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              byte_present,
	input  wire logic              end_of_message,
	input  wire logic [5:0]        pos,
	output sha_pkg::sha_cmd_t      cmd,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             word_idx
);
	import sha_pkg::*;

	typedef enum logic [2:0] {
		IDLE, PAD, INIT, ROUND, FIN, EMIT
	} state_t;

	state_t state_q;
	logic [5:0] round_q;
	logic last_q, pend_q, second_q, fin_emit_q;
	logic acc;

	assign in_ready = (state_q == IDLE);
	assign acc = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.round_idx = round_q;
		case (state_q)
			IDLE: begin
				cmd.load_byte = acc && byte_present;
			end
			PAD: begin
				if (second_q) begin
					cmd.clear_block = 1'b1;
					cmd.load_len = 1'b1;
				end else begin
					cmd.load_pad = 1'b1;
					cmd.load_len = (pos < 6'd56);
				end
			end
			INIT: cmd.start_init = 1'b1;
			ROUND: cmd.round_en = 1'b1;
			FIN: cmd.finish = 1'b1;
			EMIT: cmd.reset_hash = out_ready && (word_idx == 3'd7);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			round_q <= '0;
			last_q <= 1'b0;
			pend_q <= 1'b0;
			second_q <= 1'b0;
			fin_emit_q <= 1'b0;
			out_valid <= 1'b0;
			word_idx <= '0;
		end else begin
			case (state_q)
				IDLE: if (acc) begin
					last_q <= end_of_message;
					second_q <= 1'b0;
					fin_emit_q <= 1'b0;
					if (byte_present && pos == 6'd63) begin
						state_q <= INIT;
					end else if (end_of_message) begin
						state_q <= PAD;
					end
				end
				PAD: begin
					pend_q <= !second_q && (pos >= 6'd56);
					fin_emit_q <= second_q || (pos < 6'd56);
					second_q <= 1'b0;
					last_q <= 1'b0;
					state_q <= INIT;
				end
				INIT: begin
					round_q <= '0;
					state_q <= ROUND;
				end
				ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) state_q <= FIN;
				end
				FIN: begin
					if (last_q) begin
						state_q <= PAD;
					end else if (pend_q) begin
						pend_q <= 1'b0;
						second_q <= 1'b1;
						state_q <= PAD;
					end else begin
						state_q <= fin_emit_q ? EMIT : IDLE;
						out_valid <= fin_emit_q;
						word_idx <= '0;
					end
				end
				EMIT: if (out_ready) begin
					word_idx <= word_idx + 3'd1;
					if (word_idx == 3'd7) begin
						out_valid <= 1'b0;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/sha256_stream_hasher_top.sv
// channel | valid     | ready     | payload
// in      | in_valid  | in_ready  | msg_byte, byte_present, end_of_message
// out     | out_valid | out_ready | digest_word, word_number, last_word
// A byte item is written into the block; the 64th byte of a block adds a
// compression (one round per cycle in the shared round unit).
// End of message adds one or two padding compressions, then eight output
// transactions. Reset loads the initial hash and clears the count.
// Input is held off while compressing or emitting.
`default_nettype none
module sha256_stream_hasher_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  msg_byte,
	input  wire logic        byte_present,
	input  wire logic        end_of_message,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_number,
	output logic             last_word
);
	import sha_pkg::*;

	sha_cmd_t cmd;
	logic [5:0] pos;
	logic [31:0] hash_out [8];

	sha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.byte_present(byte_present), .end_of_message(end_of_message), .pos(pos),
		.cmd(cmd), .out_valid(out_valid), .out_ready(out_ready), .word_idx(word_number)
	);

	sha_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .msg_byte(msg_byte),
		.pos(pos), .hash_out(hash_out)
	);

	assign digest_word = hash_out[word_number];
	assign last_word = (word_number == 3'd7);
endmodule
`default_nettype wire

// File: verif/sha256_stream_hasher_top_tb.sv
`default_nettype none
module sha256_stream_hasher_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sha_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       eom;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  msg_byte = '0;
	logic        byte_present = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_number;
	logic        last_word;

	sha256_stream_hasher_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.msg_byte(msg_byte), .byte_present(byte_present), .end_of_message(end_of_message),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_number(word_number), .last_word(last_word)
	);

	always #5 clk = ~clk;

	msg_item_t    pending_items[$];
	digest_item_t expected_digests[$];
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	bit           hold_sender = 1'b0;
	int           mismatch_count = 0;
	longint       cycle_count = 0;

	logic [31:0] hash_state [8];
	logic [31:0] block_buf [16];
	logic [60:0] msg_len;

	function automatic logic [31:0] ror32(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int t = 0; t < 16; t++) w[t] = block_buf[t];
		for (int t = 16; t < 64; t++)
			w[t] = (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
				+ (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
		for (int t = 0; t < 8; t++) v[t] = hash_state[t];
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int t = 0; t < 8; t++) hash_state[t] += v[t];
	endtask

	task automatic reset_hash();
		for (int i = 0; i < 8; i++) hash_state[i] = INIT_HASH[i];
		for (int i = 0; i < 16; i++) block_buf[i] = '0;
		msg_len = '0;
	endtask

	task automatic place_byte(int pos, logic [7:0] b, bit clear_rest);
		int widx, sh;
		logic [31:0] lane;
		widx = pos >> 2;
		sh = (3 - (pos & 3)) * 8;
		lane = 32'hff << sh;
		block_buf[widx] &= ~lane;
		if (clear_rest) block_buf[widx] &= ~(lane - 1);
		block_buf[widx] |= 32'(b) << sh;
	endtask

	task automatic hash_item(msg_item_t it);
		int pos;
		logic [63:0] bits;
		if (it.present) begin
			pos = int'(msg_len[5:0]);
			place_byte(pos, it.data, 1'b0);
			msg_len = msg_len + 61'd1;
			if (pos == 63) compress_block();
		end
		if (it.eom) begin
			pos = int'(msg_len[5:0]);
			place_byte(pos, PAD_BYTE, 1'b1);
			for (int i = (pos >> 2) + 1; i < 16; i++) block_buf[i] = '0;
			if (pos >= 56) begin
				compress_block();
				for (int i = 0; i < 16; i++) block_buf[i] = '0;
			end
			bits = {msg_len, 3'b000};
			block_buf[14] = bits[63:32];
			block_buf[15] = bits[31:0];
			compress_block();
			for (int i = 0; i < 8; i++)
				expected_digests.push_back('{hash_state[i], 3'(i), i == 7});
			for (int i = 0; i < 8; i++) hash_state[i] = INIT_HASH[i];
			msg_len = '0;
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			hash_item('{msg_byte, byte_present, end_of_message});
			void'(pending_items.pop_front());
		end
		if ((!in_valid || in_ready) && arst_n) begin
			if (pending_items.size() != 0 && !hold_sender
				&& $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				msg_byte <= pending_items[0].data;
				byte_present <= pending_items[0].present;
				end_of_message <= pending_items[0].eom;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		digest_item_t exp_d;
		cycle_count <= cycle_count + 1;
		if (out_valid && out_ready) begin
			if (expected_digests.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected digest transaction %h %0d %b",
						digest_word, word_number, last_word);
			end else begin
				exp_d = expected_digests.pop_front();
				if (exp_d !== {digest_word, word_number, last_word}) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: exp %h %0d %b got %h %0d %b", exp_d.word,
							exp_d.idx, exp_d.last, digest_word, word_number, last_word);
				end
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (cycle_count > 64'd3000000) begin
			$display("sha256_stream_hasher_top_tb: FAIL");
			$finish;
		end
	end

	task automatic add_message(int len, bit end_only);
		for (int i = 0; i < len; i++)
			pending_items.push_back('{8'($urandom), 1'b1, !end_only && i == len - 1});
		if (end_only || len == 0) pending_items.push_back('{8'($urandom), 1'b0, 1'b1});
	endtask

	task automatic run_phase(int idle, int stall, int n_items);
		int base;
		int queued;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		base = pending_items.size();
		queued = 0;
		while (queued < n_items) begin
			case ($urandom_range(9))
				0: pending_items.push_back('{8'($urandom), 1'b0, 1'b0});
				1: begin add_message($urandom_range(53, 66), 1'($urandom_range(1))); end
				default: add_message($urandom_range(0, 20), 1'($urandom_range(1)));
			endcase
			queued = pending_items.size() - base;
		end
		wait (pending_items.size() == 0 && !in_valid);
	endtask

	initial begin
		reset_hash();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// directed: empty, abc-like extremes, pad boundaries, no-op
		pending_items.push_back('{8'hff, 1'b0, 1'b1});
		pending_items.push_back('{8'h00, 1'b0, 1'b0});
		pending_items.push_back('{8'h00, 1'b1, 1'b0});
		pending_items.push_back('{8'hff, 1'b1, 1'b1});
		pending_items.push_back('{8'haa, 1'b1, 1'b0});
		pending_items.push_back('{8'h55, 1'b0, 1'b1});
		for (int i = 0; i < 15; i++)
			pending_items.push_back('{8'(i * 17), 1'b1, i == 14});
		wait (pending_items.size() == 0 && !in_valid);
		for (int l = 55; l <= 56; l++) add_message(l, 1'b0);
		add_message(64, 1'b0);
		add_message(63, 1'b1);
		run_phase(0, 0, 20);
		wait (expected_digests.size() == 0);
		hold_sender = 1'b1;
		repeat (300) @(posedge clk);
		hold_sender = 1'b0;
		run_phase(66, 0, 20);
		run_phase(0, 66, 20);
		run_phase(21, 21, 20);
		wait (expected_digests.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatch_count == 0 && expected_digests.size() == 0) begin
			$display("sha256_stream_hasher_top_tb: PASS");
		end else begin
			$display("sha256_stream_hasher_top_tb: FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
